// File: rtl/bpsw_pkg.sv
package bpsw_pkg;

    localparam int HDR_BYTES = 54;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_FIRST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PAD       = 3'd5;

    // alpha modes
    localparam logic [1:0] ALPHA_BLEND  = 2'd0;
    localparam logic [1:0] ALPHA_AFTER  = 2'd1;
    localparam logic [1:0] ALPHA_BEFORE = 2'd2;

    // item kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_HEADER = 1'b1;

    typedef struct packed {
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [2:0]  channel_count;
        logic        blue_first;
        logic [1:0]  alpha_mode;
        logic [1:0]  row_pad;
        logic [31:0] file_size;
    } cfg_t;

    // one classified item: header, or up to four pixel bytes plus row padding
    typedef struct packed {
        logic            is_hdr;
        logic [3:0][7:0] bytes;
        logic [5:0]      last_idx;
    } entry_t;

endpackage

// File: rtl/bpsw_fifo.sv
module bpsw_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  bpsw_pkg::entry_t  wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output bpsw_pkg::entry_t  rd_data
);
    import bpsw_pkg::*;

    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/bpsw_front.sv
module bpsw_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bpsw_pkg::cfg_t    cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // chan0, chan1, chan2, chan3
    input  logic              s_tuser,   // kind
    output logic              q_valid,
    input  logic              q_ready,
    output bpsw_pkg::entry_t  q_data
);
    import bpsw_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

    // bg + (c - bg) * a / 255 truncated toward zero, bg either 255 or 0
    function automatic logic [7:0] blend_chan(input logic [7:0] c, input logic [7:0] a,
                                              input logic bg_high);
        logic [7:0]  mag;
        logic [15:0] prod;
        logic [15:0] t;
        logic [7:0]  q;
        mag  = bg_high ? (8'd255 - c) : c;
        prod = 16'(mag) * 16'(a);
        // exact divide by 255 for products up to 255*255
        t    = prod + {8'd0, prod[15:8]} + 16'd1;
        q    = t[15:8];
        return bg_high ? (8'd255 - q) : q;
    endfunction

    logic [CW-1:0]   col_reg;
    logic [CW-1:0]   col_next;
    logic [7:0]      d [4];
    logic [2:0]      ch_eff;
    logic [1:0]      am_eff;
    logic [1:0]      alpha_sel;
    logic [7:0]      alpha;
    logic [7:0]      x [3];
    logic [7:0]      o [3];
    logic [3:0][7:0] pix;
    logic [2:0]      npix;
    logic [EW-1:0]   w_raw;
    logic [EW-1:0]   w_eff;
    logic [EW-1:0]   col_inc;
    logic            row_end;
    logic [1:0]      pad;
    logic            accept;

    assign s_tready = q_ready;
    assign q_valid  = s_tvalid;
    assign accept   = s_tvalid && q_ready;

    assign d[0] = s_tdata[7:0];
    assign d[1] = s_tdata[15:8];
    assign d[2] = s_tdata[23:16];
    assign d[3] = s_tdata[31:24];

    always_comb
    begin
        if (cfg.channel_count == 3'd0)
        begin
            ch_eff = 3'd1;
        end
        else if (cfg.channel_count > 3'd4)
        begin
            ch_eff = 3'd4;
        end
        else
        begin
            ch_eff = cfg.channel_count;
        end

        if (cfg.alpha_mode == ALPHA_AFTER || cfg.alpha_mode == ALPHA_BEFORE)
        begin
            am_eff = cfg.alpha_mode;
        end
        else
        begin
            am_eff = ALPHA_BLEND;
        end

        alpha_sel = 2'(ch_eff - 3'd1);
        alpha     = d[alpha_sel];

        if (ch_eff <= 3'd2)
        begin
            x[0] = d[0];
            x[1] = d[0];
            x[2] = d[0];
        end
        else if (ch_eff == 3'd4 && am_eff == ALPHA_BLEND)
        begin
            // blended over magenta
            x[0] = blend_chan(d[0], d[3], 1'b1);
            x[1] = blend_chan(d[1], d[3], 1'b0);
            x[2] = blend_chan(d[2], d[3], 1'b1);
        end
        else
        begin
            x[0] = d[0];
            x[1] = d[1];
            x[2] = d[2];
        end

        if (cfg.blue_first)
        begin
            o[0] = x[2];
            o[1] = x[1];
            o[2] = x[0];
        end
        else
        begin
            o[0] = x[0];
            o[1] = x[1];
            o[2] = x[2];
        end

        case (am_eff)
            ALPHA_BEFORE:
            begin
                pix  = {o[2], o[1], o[0], alpha};
                npix = 3'd4;
            end
            ALPHA_AFTER:
            begin
                pix  = {alpha, o[2], o[1], o[0]};
                npix = 3'd4;
            end
            default:
            begin
                pix  = {8'd0, o[2], o[1], o[0]};
                npix = 3'd3;
            end
        endcase

        w_raw = EW'(cfg.image_width);
        if (w_raw == '0)
        begin
            w_eff = EW'(1);
        end
        else if (w_raw > EW'(MAX_WIDTH))
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_raw;
        end

        col_inc = EW'(col_reg) + EW'(1);
        row_end = (col_inc >= w_eff);
        pad     = row_end ? cfg.row_pad : 2'd0;

        if (s_tuser == KIND_HEADER)
        begin
            q_data.is_hdr   = 1'b1;
            q_data.bytes    = '0;
            q_data.last_idx = 6'(HDR_BYTES - 1);
            col_next        = '0;
        end
        else
        begin
            q_data.is_hdr   = 1'b0;
            q_data.bytes    = pix;
            q_data.last_idx = 6'(npix) - 6'd1 + 6'(pad);
            col_next        = row_end ? '0 : CW'(col_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
        end
    end

endmodule

// File: rtl/bpsw_back.sv
module bpsw_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bpsw_pkg::cfg_t    cfg,
    input  logic              q_valid,
    output logic              q_ready,
    input  bpsw_pkg::entry_t  q_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_byte
    output logic              m_tlast    // last
);
    import bpsw_pkg::*;

    localparam logic [7:0] SIG_B       = 8'h42;
    localparam logic [7:0] SIG_M       = 8'h4D;
    localparam logic [7:0] DATA_OFFSET = 8'(HDR_BYTES);
    localparam logic [7:0] DIB_SIZE    = 8'd40;
    localparam logic [7:0] PLANES      = 8'd1;
    localparam logic [7:0] BPP         = 8'd24;

    entry_t     cur_reg;
    logic       cur_valid_reg;
    logic [5:0] idx_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_valid_reg;
    logic [7:0] hdr_byte;
    logic [7:0] cur_byte;
    logic       emit;
    logic       final_byte;
    logic       load;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    assign emit       = cur_valid_reg && (!out_valid_reg || m_tready);
    assign final_byte = (idx_reg == cur_reg.last_idx);
    assign load       = q_valid && (!cur_valid_reg || (emit && final_byte));
    assign q_ready    = load;

    // little-endian header, offsets in bytes
    always_comb
    begin
        case (idx_reg)
            6'd0:    hdr_byte = SIG_B;
            6'd1:    hdr_byte = SIG_M;
            6'd2:    hdr_byte = cfg.file_size[7:0];
            6'd3:    hdr_byte = cfg.file_size[15:8];
            6'd4:    hdr_byte = cfg.file_size[23:16];
            6'd5:    hdr_byte = cfg.file_size[31:24];
            6'd10:   hdr_byte = DATA_OFFSET;
            6'd14:   hdr_byte = DIB_SIZE;
            6'd18:   hdr_byte = cfg.image_width[7:0];
            6'd19:   hdr_byte = {3'd0, cfg.image_width[12:8]};
            6'd22:   hdr_byte = cfg.image_height[7:0];
            6'd23:   hdr_byte = {3'd0, cfg.image_height[12:8]};
            6'd26:   hdr_byte = PLANES;
            6'd28:   hdr_byte = BPP;
            default: hdr_byte = 8'd0;
        endcase

        if (cur_reg.is_hdr)
        begin
            cur_byte = hdr_byte;
        end
        else if (idx_reg < 6'd4)
        begin
            cur_byte = cur_reg.bytes[idx_reg[1:0]];
        end
        else
        begin
            // row padding
            cur_byte = 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_data;
        end
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 6'd0;
            end
            else if (emit)
            begin
                if (final_byte)
                begin
                    cur_valid_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 6'd1;
                end
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/bmp_pixel_stream_writer.sv
// path: queue, then current-item register, then the registered byte output m_tdata
// throughput: one output byte per cycle, set by the byte-wide output register, while
// m_tready is high and bytes wait; a pixel is 3 or 4 bytes plus row_pad at a row end,
// a header 54 bytes; a two-entry queue takes items while earlier bytes still go out
// reset: asynchronous, clears the queue, column count and configuration to defaults
module bmp_pixel_stream_writer #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // chan0, chan1, chan2, chan3
    input  logic                              s_tuser,   // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // out_byte
    output logic                              m_tlast,   // last
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpsw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpsw_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bpsw_pkg::*;

    cfg_t        cfg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  chan_reg;
    logic        blue_first_reg;
    logic [1:0]  alpha_mode_reg;
    logic [1:0]  row_pad_reg;
    logic [31:0] size_reg;
    logic [14:0] row_raw;
    logic [14:0] row_bytes;
    logic [27:0] pix_bytes;
    logic        fq_valid;
    logic        fq_ready;
    entry_t      fq_data;
    logic        bq_valid;
    logic        bq_ready;
    entry_t      bq_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= 13'd1;
            height_reg     <= 13'd1;
            chan_reg       <= 3'd3;
            blue_first_reg <= 1'b1;
            alpha_mode_reg <= ALPHA_BLEND;
            row_pad_reg    <= 2'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg      <= cfg_data;
                REG_IMAGE_HEIGHT:  height_reg     <= cfg_data;
                REG_CHANNEL_COUNT: chan_reg       <= cfg_data[2:0];
                REG_BLUE_FIRST:    blue_first_reg <= cfg_data[0];
                REG_ALPHA_MODE:    alpha_mode_reg <= cfg_data[1:0];
                REG_ROW_PAD:       row_pad_reg    <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    // row stride is width*3 rounded up to a multiple of four
    assign row_raw   = {2'd0, width_reg} + {1'b0, width_reg, 1'b0} + 15'd3;
    assign row_bytes = {row_raw[14:2], 2'b00};
    assign pix_bytes = 28'(row_bytes) * 28'(height_reg);

    always_ff @(posedge clk)
    begin
        size_reg <= 32'(pix_bytes) + 32'(HDR_BYTES);
    end

    always_comb
    begin
        cfg.image_width   = width_reg;
        cfg.image_height  = height_reg;
        cfg.channel_count = chan_reg;
        cfg.blue_first    = blue_first_reg;
        cfg.alpha_mode    = alpha_mode_reg;
        cfg.row_pad       = row_pad_reg;
        cfg.file_size     = size_reg;
    end

    bpsw_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    bpsw_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (bq_valid),
        .rd_ready (bq_ready),
        .rd_data  (bq_data)
    );

    bpsw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (bq_valid),
        .q_ready  (bq_ready),
        .q_data   (bq_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
